FILE: hdl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared sizes, codes and controller/datapath interface types of the buffer
// cache tag manager.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int SLOTS      = 64;
   localparam int REF_WIDTH  = 16;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int TAG_W      = 32;
   localparam int OUT_SLOT_W = 6;
   localparam int OUT_REF_W  = 16;

   localparam logic [REF_WIDTH-1:0] REF_LIMIT = '1;

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_HIT          = 3'd0,
      ST_MISS_NEW     = 3'd1,
      ST_MISS_EVICT   = 3'd2,
      ST_EXHAUSTED    = 3'd3,
      ST_PUT_KEPT     = 3'd4,
      ST_PUT_RELEASED = 3'd5,
      ST_PUT_INVALID  = 3'd6,
      ST_SATURATED    = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUT_RD,
      S_PUT_EX,
      S_SCAN,
      S_HIT_RD,
      S_HIT_EX,
      S_MISS,
      S_EV_RD,
      S_EV_EX
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan;
      logic put_ex;
      logic hit_ex;
      logic miss_new;
      logic ev_sel;
      logic ev_ex;
      logic exhaust;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic nus_avail;
      logic rel_nonempty;
      logic rsp_free;
   } sts_type;

endpackage

FILE: hdl/block_buffer_cache_lru_unit.sv
`timescale 1ns / 1ps
// throughput: one transaction at a time, set by the one-entry-per-cycle tag scan
// the next request is taken while a finished result waits on the rsp side
// reset: synchronous, clears valid bits, the allocation count, released list and result valid
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit
// Buffer cache tag manager with reference counts and released-list eviction.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [bbc_pkg::TAG_W-1:0]      req_inode,
   input  logic [bbc_pkg::TAG_W-1:0]      req_block_index,
   input  logic [5:0]                     req_slot,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [bbc_pkg::OUT_SLOT_W-1:0] rsp_result_slot,
   output logic [bbc_pkg::OUT_REF_W-1:0]  rsp_ref_count_out,
   output logic [bbc_pkg::TAG_W-1:0]      rsp_evicted_inode,
   output logic [bbc_pkg::TAG_W-1:0]      rsp_evicted_index
);
   import bbc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and result path
   bbc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_inode         (req_inode),
      .req_block_index   (req_block_index),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_ref_count_out (rsp_ref_count_out),
      .rsp_evicted_inode (rsp_evicted_inode),
      .rsp_evicted_index (rsp_evicted_index)
   );

endmodule

FILE: hdl/bbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer of the tag manager: steps each transaction through lookup,
// read and execute phases and issues datapath commands.
// ----------------------------------------------------------------------------
module bbc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  bbc_pkg::sts_type sts,
   output bbc_pkg::cmd_type cmd
);
   import bbc_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_PUT) ? S_PUT_RD : S_SCAN;
            end
         end
         S_PUT_RD: state_in = S_PUT_EX;
         S_PUT_EX: if (sts.rsp_free) state_in = S_IDLE;
         S_SCAN: begin
            priority if (sts.scan_hit) state_in = S_HIT_RD;
            else if (sts.scan_end)     state_in = S_MISS;
            else                       state_in = state_ff;
         end
         S_HIT_RD: state_in = S_HIT_EX;
         S_HIT_EX: if (sts.rsp_free) state_in = S_IDLE;
         S_MISS: begin
            priority if (!sts.nus_avail && sts.rel_nonempty) state_in = S_EV_RD;
            else if (sts.rsp_free)                           state_in = S_IDLE;
            else                                             state_in = state_ff;
         end
         S_EV_RD: state_in = S_EV_EX;
         S_EV_EX: if (sts.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_PUT_EX: cmd.put_ex = sts.rsp_free;
         S_SCAN:   cmd.scan   = 1'b1;
         S_HIT_EX: cmd.hit_ex = sts.rsp_free;
         S_MISS: begin
            priority if (sts.nus_avail) cmd.miss_new = sts.rsp_free;
            else if (sts.rel_nonempty)  cmd.ev_sel   = 1'b1;
            else                        cmd.exhaust  = sts.rsp_free;
         end
         S_EV_EX: cmd.ev_ex = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: hdl/bbc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_dpath
// Tag, count and link memories, released list head/tail, sequential tag
// scan and the result register.
// ----------------------------------------------------------------------------
module bbc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  bbc_pkg::cmd_type                    cmd,
   output bbc_pkg::sts_type                    sts,
   input  logic                                req_type,
   input  logic [bbc_pkg::TAG_W-1:0]           req_inode,
   input  logic [bbc_pkg::TAG_W-1:0]           req_block_index,
   input  logic [5:0]                          req_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_status,
   output logic [bbc_pkg::OUT_SLOT_W-1:0]      rsp_result_slot,
   output logic [bbc_pkg::OUT_REF_W-1:0]       rsp_ref_count_out,
   output logic [bbc_pkg::TAG_W-1:0]           rsp_evicted_inode,
   output logic [bbc_pkg::TAG_W-1:0]           rsp_evicted_index
);
   import bbc_pkg::*;

   // memories
   logic [2*TAG_W-1:0]   tag_mem  [SLOTS];
   logic [REF_WIDTH-1:0] cnt_mem  [SLOTS];
   logic [SLOT_W-1:0]    next_mem [SLOTS];
   logic [SLOT_W-1:0]    prev_mem [SLOTS];

   logic [2*TAG_W-1:0]   tag_rd_ff;
   logic [REF_WIDTH-1:0] cnt_rd_ff;
   logic [SLOT_W-1:0]    next_rd_ff, prev_rd_ff;

   // transaction registers
   logic [2*TAG_W-1:0]   req_tag_ff;
   logic [5:0]           slot_raw_ff;
   logic                 in_range_ff;
   logic [SLOT_W-1:0]    tgt_ff, tgt_in;

   // control state
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     on_list_ff, on_list_in;
   logic [CNT_W-1:0]     nus_ff, nus_in;
   logic [SLOT_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic                 nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_W-1:0]    pend_idx_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [OUT_REF_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [TAG_W-1:0]     rsp_ei_ff, rsp_ei_in, rsp_ex_ff, rsp_ex_in;

   // combinational helpers
   logic [SLOT_W-1:0]    tag_addr, nus_idx;
   logic [REF_WIDTH-1:0] cur_cnt, cnt_dec, cnt_inc;
   logic                 sat, put_ok, unlink_do, push_do, emit;
   logic                 nx_we, pv_we, cnt_we, tag_we;
   logic [SLOT_W-1:0]    nx_wa, nx_wd, pv_wa, pv_wd, cnt_wa, tag_wa;
   logic [REF_WIDTH-1:0] cnt_wd;

   assign tag_addr = cmd.scan ? scan_addr_ff[SLOT_W-1:0] : tgt_ff;
   assign nus_idx  = nus_ff[SLOT_W-1:0];
   assign cur_cnt  = valid_ff[tgt_ff] ? cnt_rd_ff : '0;
   assign cnt_dec  = cur_cnt - 1'b1;
   assign cnt_inc  = cur_cnt + 1'b1;
   assign sat      = (cur_cnt == REF_LIMIT);
   assign put_ok   = in_range_ff && (cur_cnt != '0);
   assign unlink_do = (cmd.hit_ex && !sat && on_list_ff[tgt_ff]) || cmd.ev_ex;
   assign push_do   = cmd.put_ex && put_ok && (cnt_dec == '0);
   assign emit = cmd.put_ex | cmd.hit_ex | cmd.miss_new | cmd.ev_ex | cmd.exhaust;

   // status to controller
   assign sts.scan_hit     = pend_ff && valid_ff[pend_idx_ff] && (tag_rd_ff == req_tag_ff);
   assign sts.scan_end     = !pend_ff && (scan_addr_ff == CNT_W'(SLOTS));
   assign sts.nus_avail    = (nus_ff < CNT_W'(SLOTS));
   assign sts.rel_nonempty = nonempty_ff;
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   // scan address and pending compare
   always_comb begin
      scan_addr_in = scan_addr_ff;
      pend_in      = pend_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
         pend_in      = 1'b0;
      end else if (cmd.scan) begin
         pend_in = (scan_addr_ff < CNT_W'(SLOTS));
         if (scan_addr_ff < CNT_W'(SLOTS)) scan_addr_in = scan_addr_ff + 1'b1;
      end
   end

   // target slot
   always_comb begin
      tgt_in = tgt_ff;
      priority if (cmd.load)             tgt_in = SLOT_W'(req_slot);
      else if (cmd.scan && sts.scan_hit) tgt_in = pend_idx_ff;
      else if (cmd.ev_sel)               tgt_in = tail_ff;
      else                               tgt_in = tgt_ff;
   end

   // released list maintenance, allocation and memory write ports
   always_comb begin
      valid_in    = valid_ff;
      on_list_in  = on_list_ff;
      nus_in      = nus_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      nonempty_in = nonempty_ff;
      nx_we = 1'b0; nx_wa = tgt_ff; nx_wd = head_ff;
      pv_we = 1'b0; pv_wa = head_ff; pv_wd = tgt_ff;
      cnt_we = 1'b0; cnt_wa = tgt_ff; cnt_wd = '0;
      tag_we = 1'b0; tag_wa = tgt_ff;

      // unlink target from the released list
      if (unlink_do) begin
         priority if (tgt_ff == head_ff && tgt_ff == tail_ff) nonempty_in = 1'b0;
         else if (tgt_ff == head_ff) head_in = next_rd_ff;
         else if (tgt_ff == tail_ff) tail_in = prev_rd_ff;
         else begin
            nx_we = 1'b1; nx_wa = prev_rd_ff; nx_wd = next_rd_ff;
            pv_we = 1'b1; pv_wa = next_rd_ff; pv_wd = prev_rd_ff;
         end
         on_list_in[tgt_ff] = 1'b0;
      end

      // push target at the list head
      if (push_do) begin
         if (!nonempty_ff) begin
            head_in     = tgt_ff;
            tail_in     = tgt_ff;
            nonempty_in = 1'b1;
         end else begin
            nx_we = 1'b1; nx_wa = tgt_ff;  nx_wd = head_ff;
            pv_we = 1'b1; pv_wa = head_ff; pv_wd = tgt_ff;
            head_in = tgt_ff;
         end
         on_list_in[tgt_ff] = 1'b1;
      end

      // count and tag updates
      if (cmd.put_ex && put_ok) begin
         cnt_we = 1'b1; cnt_wd = cnt_dec;
      end
      if (cmd.hit_ex && !sat) begin
         cnt_we = 1'b1; cnt_wd = cnt_inc;
      end
      if (cmd.miss_new) begin
         cnt_we = 1'b1; cnt_wa = nus_idx; cnt_wd = REF_WIDTH'(1);
         tag_we = 1'b1; tag_wa = nus_idx;
         valid_in[nus_idx] = 1'b1;
         nus_in = nus_ff + 1'b1;
      end
      if (cmd.ev_ex) begin
         cnt_we = 1'b1; cnt_wd = REF_WIDTH'(1);
         tag_we = 1'b1;
      end
   end

   // result formation
   always_comb begin
      rsp_valid_in  = emit | (rsp_valid_ff & ~rsp_ready);
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_ei_in     = rsp_ei_ff;
      rsp_ex_in     = rsp_ex_ff;
      if (emit) begin
         rsp_ei_in = '0;
         rsp_ex_in = '0;
         rsp_cnt_in = '0;
         rsp_slot_in = OUT_SLOT_W'(tgt_ff);
         priority if (cmd.put_ex) begin
            rsp_slot_in = OUT_SLOT_W'(slot_raw_ff);
            priority if (!put_ok)  rsp_status_in = ST_PUT_INVALID;
            else if (cnt_dec == '0) rsp_status_in = ST_PUT_RELEASED;
            else begin
               rsp_status_in = ST_PUT_KEPT;
               rsp_cnt_in    = OUT_REF_W'(cnt_dec);
            end
         end else if (cmd.hit_ex) begin
            rsp_status_in = sat ? ST_SATURATED : ST_HIT;
            rsp_cnt_in    = sat ? OUT_REF_W'(REF_LIMIT) : OUT_REF_W'(cnt_inc);
         end else if (cmd.miss_new) begin
            rsp_status_in = ST_MISS_NEW;
            rsp_slot_in   = OUT_SLOT_W'(nus_idx);
            rsp_cnt_in    = OUT_REF_W'(1);
         end else if (cmd.ev_ex) begin
            rsp_status_in = ST_MISS_EVICT;
            rsp_cnt_in    = OUT_REF_W'(1);
            rsp_ei_in     = tag_rd_ff[2*TAG_W-1:TAG_W];
            rsp_ex_in     = tag_rd_ff[TAG_W-1:0];
         end else begin
            rsp_status_in = ST_EXHAUSTED;
            rsp_slot_in   = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         on_list_ff   <= '0;
         nus_ff       <= '0;
         nonempty_ff  <= 1'b0;
         scan_addr_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         on_list_ff   <= on_list_in;
         nus_ff       <= nus_in;
         nonempty_ff  <= nonempty_in;
         scan_addr_ff <= scan_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      tgt_ff        <= tgt_in;
      pend_idx_ff   <= scan_addr_ff[SLOT_W-1:0];
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_ei_ff     <= rsp_ei_in;
      rsp_ex_ff     <= rsp_ex_in;
      if (cmd.load) begin
         req_tag_ff  <= {req_inode, req_block_index};
         slot_raw_ff <= req_slot;
         in_range_ff <= (32'(req_slot) < 32'(SLOTS)) && (req_type == REQ_PUT);
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      tag_rd_ff  <= tag_mem[tag_addr];
      cnt_rd_ff  <= cnt_mem[tgt_ff];
      next_rd_ff <= next_mem[tgt_ff];
      prev_rd_ff <= prev_mem[tgt_ff];
      if (tag_we) tag_mem[tag_wa]  <= req_tag_ff;
      if (cnt_we) cnt_mem[cnt_wa]  <= cnt_wd;
      if (nx_we)  next_mem[nx_wa]  <= nx_wd;
      if (pv_we)  prev_mem[pv_wa]  <= pv_wd;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_slot   = rsp_slot_ff;
   assign rsp_ref_count_out = rsp_cnt_ff;
   assign rsp_evicted_inode = rsp_ei_ff;
   assign rsp_evicted_index = rsp_ex_ff;

   // checks
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(nus_ff))
      else $error("valid slots do not match allocation count");
   a_list_empty: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> (on_list_ff == '0))
      else $error("slot marked released while list is empty");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result written over a pending transaction");
   a_nus_range: assert property (@(posedge clock) disable iff (reset)
      nus_ff <= CNT_W'(SLOTS))
      else $error("allocation count out of range");

endmodule

FILE: verif/block_buffer_cache_lru_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit_tb
// Drives get and put transactions into the buffer cache tag manager. A
// behavioral copy of the tag store, the reference counts and the released
// list predicts each response, and a monitor compares every field. Both the
// request and the response side idle at random.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit_tb;
   import bbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAG_POOL       = 100;
   localparam int RAMP_GETS      = 30;

   typedef struct packed {
      status_type  status;
      logic [5:0]  slot;
      logic [15:0] count;
      logic [31:0] ev_inode;
      logic [31:0] ev_index;
   } lookup_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [31:0] req_inode;
   logic [31:0] req_block_index;
   logic [5:0]  req_slot;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_result_slot;
   logic [15:0] rsp_ref_count_out;
   logic [31:0] rsp_evicted_inode;
   logic [31:0] rsp_evicted_index;

   // shadow copy of the cache bookkeeping
   logic [31:0]          shadow_inode [SLOTS];
   logic [31:0]          shadow_index [SLOTS];
   logic                 shadow_valid [SLOTS];
   logic [REF_WIDTH-1:0] shadow_refs  [SLOTS];
   logic                 shadow_listed[SLOTS];
   logic [5:0]           shadow_next  [SLOTS];
   logic [5:0]           shadow_prev  [SLOTS];
   int                   shadow_fresh;
   logic [5:0]           lru_head;
   logic [5:0]           lru_tail;
   logic                 lru_busy;

   lookup_result_type pending_results[$];
   logic [31:0]    pool_inode[TAG_POOL];
   logic [31:0]    pool_index[TAG_POOL];

   int mismatches;
   int status_seen[8];
   int idle_cycles;
   bit quiet;

   block_buffer_cache_lru_unit dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // released list maintenance
   task automatic lru_push(input logic [5:0] s);
      if (!lru_busy) begin
         lru_head = s;
         lru_tail = s;
         lru_busy = 1'b1;
      end else begin
         shadow_next[s]        = lru_head;
         shadow_prev[lru_head] = s;
         lru_head              = s;
      end
      shadow_prev[s]   = s;
      shadow_listed[s] = 1'b1;
   endtask

   task automatic lru_unlink(input logic [5:0] s);
      logic [5:0] nx;
      logic [5:0] pv;
      nx = shadow_next[s];
      pv = shadow_prev[s];
      if (s == lru_head && s == lru_tail) lru_busy = 1'b0;
      else if (s == lru_head) lru_head = nx;
      else if (s == lru_tail) lru_tail = pv;
      else begin
         shadow_next[pv] = nx;
         shadow_prev[nx] = pv;
      end
      shadow_listed[s] = 1'b0;
   endtask

   // response for one transaction, updating the shadow state
   task automatic predict_lookup(input logic kind, input logic [31:0] ino,
                                 input logic [31:0] idx, input logic [5:0] sl,
                                 output lookup_result_type r);
      logic [5:0] s;
      r = '0;
      if (kind == REQ_PUT) begin
         r.slot = sl;
         if (shadow_refs[sl] == 0) begin
            r.status = ST_PUT_INVALID;
         end else begin
            shadow_refs[sl]--;
            if (shadow_refs[sl] == 0) begin
               lru_push(sl);
               r.status = ST_PUT_RELEASED;
            end else begin
               r.status = ST_PUT_KEPT;
               r.count  = shadow_refs[sl];
            end
         end
         return;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_valid[i] && shadow_inode[i] == ino && shadow_index[i] == idx) begin
            r.slot = 6'(i);
            if (shadow_refs[i] == REF_LIMIT) begin
               r.status = ST_SATURATED;
               r.count  = REF_LIMIT;
            end else begin
               if (shadow_listed[i]) lru_unlink(6'(i));
               shadow_refs[i]++;
               r.status = ST_HIT;
               r.count  = shadow_refs[i];
            end
            return;
         end
      end
      if (shadow_fresh < SLOTS) begin
         s = 6'(shadow_fresh);
         shadow_fresh++;
         r.status = ST_MISS_NEW;
      end else if (lru_busy) begin
         s = lru_tail;
         lru_unlink(s);
         r.status   = ST_MISS_EVICT;
         r.ev_inode = shadow_inode[s];
         r.ev_index = shadow_index[s];
      end else begin
         r.status = ST_EXHAUSTED;
         return;
      end
      shadow_inode[s] = ino;
      shadow_index[s] = idx;
      shadow_valid[s] = 1'b1;
      shadow_refs[s]  = REF_WIDTH'(1);
      r.slot          = s;
      r.count         = 16'd1;
   endtask

   // one transaction on the request side
   task automatic send_request(input logic kind, input logic [31:0] ino,
                               input logic [31:0] idx, input logic [5:0] sl);
      int gap;
      lookup_result_type r;
      gap = quiet ? 0 : $urandom_range(9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_inode       <= ino;
      req_block_index <= idx;
      req_slot        <= sl;
      do @(posedge clock); while (!req_ready);
      predict_lookup(kind, ino, idx, sl, r);
      pending_results.push_back(r);
   endtask

   task automatic get_block(input logic [31:0] ino, input logic [31:0] idx);
      send_request(REQ_GET, ino, idx, 6'($urandom_range(63)));
   endtask

   task automatic put_slot(input logic [5:0] sl);
      send_request(REQ_PUT, $urandom, $urandom, sl);
   endtask

   // response side stall pattern
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         n = quiet ? 0 : $urandom_range(9);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // response checker
   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d slot %0d", rsp_status,
                        rsp_result_slot);
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_result_slot !== e.slot ||
                rsp_ref_count_out !== e.count || rsp_evicted_inode !== e.ev_inode ||
                rsp_evicted_index !== e.ev_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d sl %0d cnt %0d ev %h/%h, got st %0d sl %0d cnt %0d ev %h/%h",
                           e.status, e.slot, e.count, e.ev_inode, e.ev_index, rsp_status,
                           rsp_result_slot, rsp_ref_count_out, rsp_evicted_inode,
                           rsp_evicted_index);
            end
         end
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // extremes, hits on released slots, puts on empty slots
   task automatic test_directed();
      get_block(32'h0, 32'h0);
      get_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      get_block(32'h0, 32'hFFFF_FFFF);
      get_block(32'hFFFF_FFFF, 32'h0);
      get_block(32'h0, 32'h0);
      put_slot(6'd0);
      put_slot(6'd0);
      put_slot(6'd0);
      put_slot(6'd63);
      put_slot(6'd1);
      put_slot(6'd2);
      get_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      get_block(32'h0, 32'h0);
      put_slot(6'd1);
      put_slot(6'd0);
   endtask

   // back to back hits that raise one slot to a high count, then one put on it
   task automatic test_saturation();
      quiet = 1'b1;
      for (int i = 0; i < RAMP_GETS; i++) get_block(32'h5A5A_0001, 32'hA5A5_0002);
      put_slot(pending_results[$].slot);
      quiet = 1'b0;
   endtask

   // mixed traffic over a tag pool larger than the cache
   task automatic test_random_traffic(input int items, input int get_pct);
      int held[$];
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(99) < get_pct) begin
            int t;
            t = $urandom_range(TAG_POOL - 1);
            if ($urandom_range(19) == 0) get_block($urandom, $urandom);
            else get_block(pool_inode[t], pool_index[t]);
         end else begin
            held = {};
            for (int i = 0; i < SLOTS; i++)
               if (shadow_refs[i] != 0 && shadow_refs[i] < 1000) held.push_back(i);
            if (held.size() > 0 && $urandom_range(9) < 8)
               put_slot(6'(held[$urandom_range(held.size() - 1)]));
            else put_slot(6'($urandom_range(63)));
         end
      end
   endtask

   initial begin
      int wait_cycles;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_GET;
      req_inode       = '0;
      req_block_index = '0;
      req_slot        = '0;
      mismatches      = 0;
      quiet           = 1'b0;
      shadow_fresh    = 0;
      lru_busy        = 1'b0;
      lru_head        = '0;
      lru_tail        = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i]  = 1'b0;
         shadow_refs[i]   = '0;
         shadow_listed[i] = 1'b0;
         shadow_next[i]   = '0;
         shadow_prev[i]   = '0;
      end
      for (int i = 0; i < TAG_POOL; i++) begin
         pool_inode[i] = (i % 4 == 0) ? 32'h0 : $urandom;
         pool_index[i] = $urandom;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_saturation();
      test_random_traffic(300, 90);
      test_random_traffic(250, 40);
      quiet = 1'b1;
      test_random_traffic(150, 60);
      quiet = 1'b0;
      test_random_traffic(300, 75);
      test_random_traffic(250, 30);
      test_random_traffic(300, 65);
      req_valid <= 1'b0;

      // drain
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * SLOTS + 20) @(posedge clock);

      $display("covered hit %0d, new %0d, evict %0d, exhausted %0d, saturated %0d",
               status_seen[ST_HIT], status_seen[ST_MISS_NEW], status_seen[ST_MISS_EVICT],
               status_seen[ST_EXHAUSTED], status_seen[ST_SATURATED]);
      $display("put kept %0d, released %0d, invalid %0d; %0d mismatches",
               status_seen[ST_PUT_KEPT], status_seen[ST_PUT_RELEASED],
               status_seen[ST_PUT_INVALID], mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/bbc_pkg.sv
hdl/bbc_ctrl.sv
hdl/bbc_dpath.sv
hdl/block_buffer_cache_lru_unit.sv
verif/block_buffer_cache_lru_unit_tb.sv
